FILE: hw/rtl/gtfc_pkg.sv
// gtfc_pkg: shared types and constants of the gap timeout frame collector.
// Used by gtfc_frame_buf, gap_timeout_frame_collector_unit and the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gtfc_pkg;

    // Frame store depth and derived widths
    localparam int FRAME_DEPTH = 32;
    localparam int ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 5;
    localparam int LEN_W    = 6;
    localparam int TIMER_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Register reset values
    localparam logic [TIMER_W-1:0] GAP_RESET  = 16'd5;
    localparam logic [TIMER_W-1:0] IDLE_RESET = 16'd60000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RELOAD = 1'b1;

    // Input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Frame store write request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr_req;

    // Frame read-out command
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] len;
    } t_emit_cmd;

    // One result item
    typedef struct packed {
        logic              last;
        logic [LEN_W-1:0]  len;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } t_out_item;

endpackage

`default_nettype wire

FILE: hw/rtl/gtfc_frame_buf.sv
// gtfc_frame_buf: frame store memory, read-out sequencer and 2-entry output queue.
// Depends on gtfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtfc_frame_buf (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  gtfc_pkg::t_wr_req    i_wr,
    input  gtfc_pkg::t_emit_cmd  i_cmd,
    output logic                 o_busy,
    output logic                 o_item_valid,
    input  wire                  i_item_ready,
    output gtfc_pkg::t_out_item  o_item
);
    import gtfc_pkg::*;

    logic [BYTE_W-1:0] mem [FRAME_DEPTH];

    logic              r_active;
    logic [CNT_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_len;
    logic              r_rd_vld;
    logic [ADDR_W-1:0] r_rd_idx;
    logic              r_rd_last;
    logic [BYTE_W-1:0] r_rd_data;

    t_out_item         r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    logic              pop;
    logic              issue;
    logic [1:0]        used;
    logic [CNT_W-1:0]  ptr_inc;
    logic              ptr_last;
    t_out_item         push_item;

    assign o_busy       = r_active;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];
    assign pop          = o_item_valid && i_item_ready;

    // Reads in flight plus queued items never exceed the queue depth
    assign used     = r_cnt + {1'b0, r_rd_vld};
    assign issue    = r_active && ((used < 2'd2) || ((used == 2'd2) && pop));
    assign ptr_inc  = r_ptr + 1'b1;
    assign ptr_last = (ptr_inc == r_len);

    always_comb begin
        logic [31:0] idx_ext;
        logic [31:0] len_ext;
        idx_ext = 32'(r_rd_idx);
        len_ext = 32'(r_len);
        push_item.data = r_rd_data;
        push_item.idx  = idx_ext[IDX_W-1:0];
        push_item.len  = len_ext[LEN_W-1:0];
        push_item.last = r_rd_last;
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (issue) begin
            r_rd_data <= mem[r_ptr[ADDR_W-1:0]];
            r_rd_idx  <= r_ptr[ADDR_W-1:0];
            r_rd_last <= ptr_last;
        end
        if (i_cmd.start) begin
            r_len <= i_cmd.len;
        end
        if (r_rd_vld) begin
            r_q[r_wp] <= push_item;
        end
    end

    // Sequencer and queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_rd_vld <= issue;
            if (i_cmd.start) begin
                r_active <= 1'b1;
                r_ptr    <= '0;
            end else if (issue) begin
                r_ptr <= ptr_inc;
                if (ptr_last) begin
                    r_active <= 1'b0;
                end
            end
            if (r_rd_vld) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, r_rd_vld} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gap_timeout_frame_collector_unit.sv
// gap_timeout_frame_collector_unit: top level of the inter-byte idle timeout framer.
// Depends on gtfc_pkg and gtfc_frame_buf.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// - Slave stream: s_axis_tuser is the opcode (0 = received byte, 1 = one tick),
//   s_axis_tdata carries the received byte. A byte request or a tick request that
//   closes no frame is taken at once; s_axis_tready stays high while no frame is read out.
// - A byte is stored while the silence timer runs and the 32-byte store has room;
//   it reloads the timer with gap_ticks. A byte to a full store is dropped.
// - A tick that brings the timer to zero reloads it with idle_reload and, if bytes are
//   held, starts read-out of the frame: one result per byte on the master stream,
//   each passing through the registered store read and the output queue, one per
//   cycle while m_axis_tready is high. The single read port of the frame store sets
//   that rate.
// - When the receiver stalls, read-out pauses behind a 2-entry output queue; the
//   slave side reopens once every byte has been read from the store.
// - Reset: gap_ticks = 5, idle_reload = 60000, timer = 60000, store empty. The frame
//   store itself is not cleared; only written entries are ever read.
// - Configuration: write i_cfg_data to register i_cfg_idx (0 gap_ticks,
//   1 idle_reload) while idle; a value of zero is taken as one.
module gap_timeout_frame_collector_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write port
    input  wire         i_cfg_we,
    input  wire [gtfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [gtfc_pkg::CFG_W-1:0]     i_cfg_data,
    // slave stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [gtfc_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // [7:0] rx_byte
    input  wire         s_axis_tuser,                      // [0] opcode
    // master stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [gtfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // [7:0] frame_byte,
                                                           // [12:8] byte_index,
                                                           // [18:13] frame_length,
                                                           // [23:19] zero
    output logic        m_axis_tlast                       // last_byte
);
    import gtfc_pkg::*;

    logic [TIMER_W-1:0] r_gap_ticks;
    logic [TIMER_W-1:0] r_idle_reload;
    logic [TIMER_W-1:0] r_timer;
    logic [CNT_W-1:0]   r_count;

    logic               in_acc;
    logic               emit_busy;
    logic [TIMER_W-1:0] timer_dec;
    logic [CFG_W-1:0]   cfg_clamped;
    logic               store_ok;
    logic               expire;
    t_wr_req            wr;
    t_emit_cmd          cmd;
    t_out_item          item;

    // Hold off requests while the store is read out; this keeps writes away from
    // entries still being read.
    assign s_axis_tready = !emit_busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign timer_dec   = r_timer - 1'b1;
    assign cfg_clamped = (i_cfg_data == '0) ? CFG_W'(1) : i_cfg_data;

    assign store_ok = in_acc && (s_axis_tuser == OP_BYTE) && (r_timer != '0)
                      && (r_count < CNT_W'(FRAME_DEPTH));
    assign expire   = in_acc && (s_axis_tuser == OP_TICK) && (r_timer != '0)
                      && (timer_dec == '0);

    assign wr.we   = store_ok;
    assign wr.addr = r_count[ADDR_W-1:0];
    assign wr.data = s_axis_tdata[BYTE_W-1:0];

    assign cmd.start = expire && (r_count != '0);
    assign cmd.len   = r_count;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ticks   <= GAP_RESET;
            r_idle_reload <= IDLE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAP_TICKS:   r_gap_ticks   <= cfg_clamped;
                CFG_IDLE_RELOAD: r_idle_reload <= cfg_clamped;
                default: ;
            endcase
        end
    end

    // Silence timer and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= IDLE_RESET;
            r_count <= '0;
        end else if (store_ok) begin
            r_timer <= r_gap_ticks;
            r_count <= r_count + 1'b1;
        end else if (expire) begin
            // close the frame; read-out starts from the command this cycle
            r_timer <= r_idle_reload;
            r_count <= '0;
        end else if (in_acc && (s_axis_tuser == OP_TICK) && (r_timer != '0)) begin
            r_timer <= timer_dec;
        end
    end

    gtfc_frame_buf u_frame_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (wr),
        .i_cmd        (cmd),
        .o_busy       (emit_busy),
        .o_item_valid (m_axis_tvalid),
        .i_item_ready (m_axis_tready),
        .o_item       (item)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - BYTE_W - IDX_W - LEN_W){1'b0}},
                           item.len, item.idx, item.data};
    assign m_axis_tlast = item.last;

    // Timer reloads are clamped, so it never rests at zero
    a_timer_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer != '0)
        else $error("silence timer reached zero");

    // Count stays within the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FRAME_DEPTH))
        else $error("byte count beyond frame depth");

    // No store write while a frame is being read out
    a_no_write_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_busy |-> !wr.we)
        else $error("store write during read-out");

    // A frame closing with bytes held starts read-out on the next cycle
    a_start_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> emit_busy && !s_axis_tready)
        else $error("read-out did not start");

endmodule

`default_nettype wire

FILE: tb/gtfc_frame_checker.sv
// gtfc_frame_checker: watches the configuration port and both streams of the frame collector,
// predicts every frame byte on its own and compares each result against the oldest one due.
// Depends on gtfc_pkg for widths, opcodes, register indexes and reset values.
`timescale 1ns / 1ps

module gtfc_frame_checker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [gtfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [gtfc_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                           i_req_valid,
    input  wire                           i_req_ready,
    input  wire [gtfc_pkg::IN_TDATA_W-1:0] i_req_byte,   // [7:0] rx_byte
    input  wire                           i_req_op,      // [0] opcode
    input  wire                           i_res_valid,
    input  wire                           i_res_ready,
    input  wire [gtfc_pkg::OUT_TDATA_W-1:0] i_res_data,  // [7:0] frame_byte, [12:8] byte_index,
                                                         // [18:13] frame_length, [23:19] zero
    input  wire                           i_res_last,    // last_byte
    output int                            o_error_count,
    output int                            o_bytes_due
);
    import gtfc_pkg::*;

    localparam int PAD_LO = BYTE_W + IDX_W + LEN_W;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_frame_byte;

    logic [TIMER_W-1:0] gap_reload;
    logic [TIMER_W-1:0] idle_reload;
    logic [TIMER_W-1:0] silence_timer;
    logic [CNT_W-1:0]   held;
    logic [BYTE_W-1:0]  held_bytes [FRAME_DEPTH];
    t_frame_byte        frame_bytes_due [$];

    // a zero reload would stall the timer, so it counts as one
    function automatic logic [TIMER_W-1:0] reload_of(input logic [CFG_W-1:0] value);
        return (value == '0) ? TIMER_W'(1) : TIMER_W'(value);
    endfunction

    // Advance the collector by one accepted request and queue the frame it closes, if any.
    task automatic collect_request(input logic op, input logic [BYTE_W-1:0] rx);
        int          k;
        t_frame_byte fb;
        if (op == OP_BYTE) begin
            // full store or stopped timer: drop the byte, leave the timer alone
            if (silence_timer != '0 && held < FRAME_DEPTH) begin
                held_bytes[held[ADDR_W-1:0]] = rx;
                held = held + 1'b1;
                silence_timer = gap_reload;
            end
        end else if (silence_timer != '0) begin
            silence_timer = silence_timer - 1'b1;
            if (silence_timer == '0) begin
                for (k = 0; k < held; k++) begin
                    fb.data = held_bytes[k];
                    fb.idx  = IDX_W'(k);
                    fb.len  = LEN_W'(held);
                    fb.last = (k + 1 == held);
                    frame_bytes_due.push_back(fb);
                end
                held = '0;
                silence_timer = idle_reload;
            end
        end
    endtask

    task automatic compare_frame_byte;
        t_frame_byte want;
        if (frame_bytes_due.size() == 0) begin
            $error("unexpected frame byte: data %0h index %0d length %0d last %0b",
                   i_res_data[BYTE_W-1:0], i_res_data[BYTE_W+:IDX_W],
                   i_res_data[BYTE_W+IDX_W+:LEN_W], i_res_last);
            o_error_count++;
        end else begin
            want = frame_bytes_due.pop_front();
            if (i_res_data[BYTE_W-1:0] != want.data) begin
                $error("frame_byte: expected %0h, got %0h", want.data, i_res_data[BYTE_W-1:0]);
                o_error_count++;
            end
            if (i_res_data[BYTE_W+:IDX_W] != want.idx) begin
                $error("byte_index: expected %0d, got %0d", want.idx, i_res_data[BYTE_W+:IDX_W]);
                o_error_count++;
            end
            if (i_res_data[BYTE_W+IDX_W+:LEN_W] != want.len) begin
                $error("frame_length: expected %0d, got %0d", want.len,
                       i_res_data[BYTE_W+IDX_W+:LEN_W]);
                o_error_count++;
            end
            if (i_res_last != want.last) begin
                $error("last_byte: expected %0b, got %0b", want.last, i_res_last);
                o_error_count++;
            end
            if (i_res_data[OUT_TDATA_W-1:PAD_LO] != '0) begin
                $error("tdata padding: expected 0, got %0h", i_res_data[OUT_TDATA_W-1:PAD_LO]);
                o_error_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gap_reload    = GAP_RESET;
            idle_reload   = IDLE_RESET;
            silence_timer = IDLE_RESET;
            held          = '0;
            o_error_count = 0;
            frame_bytes_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_GAP_TICKS)
                    gap_reload = reload_of(i_cfg_data);
                else if (i_cfg_idx == CFG_IDLE_RELOAD)
                    idle_reload = reload_of(i_cfg_data);
            end
            if (i_req_valid && i_req_ready)
                collect_request(i_req_op, i_req_byte);
            if (i_res_valid && i_res_ready)
                compare_frame_byte();
        end
        o_bytes_due = frame_bytes_due.size();
    end

endmodule

FILE: tb/tb.sv
// tb: top of the frame collector testbench; drives byte and tick requests, configuration
// writes and random back-pressure, and reports the verdict.
// Depends on gtfc_pkg, gap_timeout_frame_collector_unit and gtfc_frame_checker.
`timescale 1ns / 1ps

module tb;
    import gtfc_pkg::*;

    localparam int RANDOM_REQUESTS = 410;
    localparam int SETTLE_CYCLES   = 8;        // margin for a read-out that is still starting
    localparam int CYCLE_LIMIT     = 200_000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx  = CFG_GAP_TICKS;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = OP_BYTE;
    logic                   m_tready = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;
    wire                    m_tlast;

    int error_count;
    int bytes_due;
    int requests_sent = 0;
    int cycle_count   = 0;
    bit no_idle       = 1'b0;  // set for stretches without gaps or stalls

    always #10 clk = ~clk;

    gap_timeout_frame_collector_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),   // [7:0] rx_byte
        .s_axis_tuser  (s_tuser),   // [0] opcode
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),   // [7:0] frame_byte, [12:8] byte_index, [18:13] frame_length
        .m_axis_tlast  (m_tlast)    // last_byte
    );

    gtfc_frame_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_req_valid   (s_tvalid),
        .i_req_ready   (s_tready),
        .i_req_byte    (s_tdata),
        .i_req_op      (s_tuser),
        .i_res_valid   (m_tvalid),
        .i_res_ready   (m_tready),
        .i_res_data    (m_tdata),
        .i_res_last    (m_tlast),
        .o_error_count (error_count),
        .o_bytes_due   (bytes_due)
    );

    // Hard stop: a hung handshake or a frame that never drains ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Receiver: stall at random before each result, then hold tready until one is taken.
    // Keep tready high across back-to-back accepts so it never drops and rises in one step.
    initial begin : result_sink
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Present one request after a random gap; return at the edge that accepts it.
    // Leave tvalid high on return: the next call lowers it only if it draws a gap.
    task automatic send_request(input logic op, input logic [IN_TDATA_W-1:0] value);
        int gap_cycles;
        gap_cycles = no_idle ? 0 : $urandom_range(0, 4);
        if (gap_cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic send_byte(input logic [IN_TDATA_W-1:0] value);
        send_request(OP_BYTE, value);
    endtask

    // tdata is a don't-care on ticks; randomize it anyway so its bits keep toggling
    task automatic send_ticks(input int count);
        repeat (count) send_request(OP_TICK, IN_TDATA_W'($urandom));
    endtask

    // Drop tvalid and wait until every predicted frame byte has come out, plus a margin
    // for a tick whose read-out might still be starting.
    task automatic settle;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (bytes_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; only called once the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // A well-formed frame: bytes spaced by fewer ticks than the gap, then enough ticks to
    // close it. Now and then a pause runs the full gap and splits the frame. Past 32 bytes
    // the extra bytes land on a full store, and more are mixed into the closing ticks so
    // that a dropped byte that wrongly reloads the timer shows up as a late frame.
    task automatic send_frame(input int length, input int gap_eff);
        int k;
        int pause;
        for (k = 0; k < length; k++) begin
            send_byte(IN_TDATA_W'($urandom));
            if (k < length - 1) begin
                if ($urandom_range(0, 7) == 0)
                    pause = gap_eff;
                else
                    pause = $urandom_range(0, (gap_eff - 1 < 2) ? gap_eff - 1 : 2);
                send_ticks(pause);
            end
        end
        for (k = 0; k < gap_eff; k++) begin
            if (length > FRAME_DEPTH && $urandom_range(0, 2) == 0)
                send_byte(IN_TDATA_W'($urandom));
            send_ticks(1);
        end
    endtask

    initial begin : stimulus
        int gap_val;
        int idle_val;
        int gap_eff;
        int idle_eff;
        int length;
        int random_start;
        bit first_phase;

        // hold reset, then release it once
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: gap of 5 ticks closes a frame of the byte extremes.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_ticks(5);
        settle();

        // Zero written to both reloads acts as one: every tick expires the timer.
        // Close a one-byte frame, expire once with an empty store, close another.
        write_reg(CFG_GAP_TICKS, '0);
        write_reg(CFG_IDLE_RELOAD, '0);
        send_byte(8'h5A);
        send_ticks(1);
        send_ticks(1);
        send_byte(8'h3C);
        send_ticks(1);
        settle();

        // Largest reloads: the timer must keep running through a handful of ticks.
        // Then shrink the gap; the next byte reloads with it and one tick closes all three.
        write_reg(CFG_GAP_TICKS, 16'hFFFF);
        write_reg(CFG_IDLE_RELOAD, 16'hFFFF);
        send_byte(8'h81);
        send_byte(8'h7E);
        send_ticks(6);
        settle();
        write_reg(CFG_GAP_TICKS, 16'd1);
        send_byte(8'h42);
        send_ticks(1);
        settle();

        // Random phases: fresh settings, one to three frames, and some noise in between.
        random_start = requests_sent;
        first_phase  = 1'b1;
        while (requests_sent < random_start + RANDOM_REQUESTS) begin
            settle();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap_val = $urandom_range(1, 4);
                6, 7:             gap_val = $urandom_range(5, 12);
                8:                gap_val = 0;
                default:          gap_val = $urandom_range(13, 30);
            endcase
            if ($urandom_range(0, 3) == 0)
                idle_val = $urandom_range(0, 1) ? 60000 : 65535;
            else
                idle_val = $urandom_range(0, 6);
            write_reg(CFG_GAP_TICKS, CFG_W'(gap_val));
            write_reg(CFG_IDLE_RELOAD, CFG_W'(idle_val));
            gap_eff  = (gap_val == 0) ? 1 : gap_val;
            idle_eff = (idle_val == 0) ? 1 : idle_val;
            no_idle  = ($urandom_range(0, 3) == 0);

            repeat ($urandom_range(1, 3)) begin
                // open with an overfilled store, then mostly short frames
                if (first_phase)
                    length = FRAME_DEPTH + 2;
                else if ($urandom_range(0, 9) == 0)
                    length = $urandom_range(FRAME_DEPTH + 1, FRAME_DEPTH + 4);
                else if ($urandom_range(0, 3) == 0)
                    length = $urandom_range(13, FRAME_DEPTH);
                else
                    length = $urandom_range(1, 6);
                first_phase = 1'b0;
                send_frame(length, gap_eff);

                // noise: idle ticks (an empty expiry when the idle reload is short)
                // and stray requests of either kind
                if ($urandom_range(0, 2) == 0)
                    send_ticks((idle_eff <= 8) ? $urandom_range(0, idle_eff + 1)
                                               : $urandom_range(1, 3));
                if ($urandom_range(0, 4) == 0)
                    send_request(1'($urandom_range(0, 1)), IN_TDATA_W'($urandom));
            end
        end

        no_idle = 1'b0;
        settle();
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
